// ----- design/ks_pkg.sv -----
// Shared types and constants for the keyframe linear sampler.
// No dependencies; imported by every module of the block.
`default_nettype none
package ks_pkg;

  localparam int KS_MAX_KEYS_DEF = 16;
  localparam int SLOT_W          = 4;
  localparam int CNT_W           = 5;
  localparam int TIME_W          = 32;
  localparam int VAL_W           = 32;
  localparam int FRAC_W          = 16;
  localparam int SEG_W           = 4;
  localparam int NCOMP           = 3;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 104;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                     is_query;
    logic [SLOT_W-1:0]        slot;
    logic [TIME_W-1:0]        time_point;
    logic signed [VAL_W-1:0]  vz;
    logic signed [VAL_W-1:0]  vy;
    logic signed [VAL_W-1:0]  vx;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]        time_point;
    logic signed [VAL_W-1:0]  vz;
    logic signed [VAL_W-1:0]  vy;
    logic signed [VAL_W-1:0]  vx;
  } key_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD0,
    BK_WALK,
    BK_DIV,
    BK_MUL,
    BK_ADD,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

// ----- design/keyframe_linear_sampler.sv -----
// Top level of the keyframe linear sampler: key_count register, front queue
// and back engine. Depends on ks_pkg, ks_front, ks_back.
//
//  Channel  Dir  Handshake             Payload
//  in_      in   in_tvalid/in_tready   tuser: kind; tdata: slot, time, x, y, z
//  out_     out  out_tvalid/out_tready tdata: x, y, z, segment_start
//  cfg_     in   cfg_wr_en             cfg_wr_data: key_count
//
// A load item is written to the key table from the idle state. A query
// that settles on the first key, or runs past every key, returns that key.
// An interpolating query first walks the segments, one table read for each
// key stepped over (at most n - 1 for n keys in use), then runs the
// restoring divider (16 quotient bits and the done flag), then takes each
// component through the shared multiplier, a multiply and an add step. The
// two-entry queue keeps taking items while the engine works; a full output
// register stalls only the engine.
// Reset is synchronous and active low; the key table has no reset.
`default_nettype none
module keyframe_linear_sampler #(
  parameter int MAX_KEYS = ks_pkg::KS_MAX_KEYS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire                             in_tuser,  // kind
  input  wire [ks_pkg::IN_TDATA_W-1:0]    in_tdata,  // key_slot, time_point, value_x/y/z
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [ks_pkg::OUT_TDATA_W-1:0]  out_tdata, // out_x, out_y, out_z, segment_start
  input  wire                             cfg_wr_en,
  input  wire [ks_pkg::CNT_W-1:0]         cfg_wr_data
);
  import ks_pkg::*;

  logic [CNT_W-1:0] key_count_r;
  logic             q_valid, q_pop;
  item_t            q_item;

  // key_count resets to one key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      key_count_r <= cfg_wr_data;
    end
  end

  ks_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ks_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_count  (key_count_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- design/ks_front.sv -----
// Front end: accepts items, classifies them, and queues them (two deep).
// Depends on ks_pkg.
`default_nettype none
module ks_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire                        in_tuser,
  input  wire [ks_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                       q_valid,
  output ks_pkg::item_t              q_item,
  input  wire                        q_pop
);
  import ks_pkg::*;

  item_t      fifo_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  item_t      item_in;
  logic       push;

  always_comb begin
    item_in.is_query   = (in_tuser == KIND_QUERY);
    item_in.slot       = in_tdata[3:0];
    item_in.time_point = in_tdata[35:4];
    item_in.vx         = in_tdata[67:36];
    item_in.vy         = in_tdata[99:68];
    item_in.vz         = in_tdata[131:100];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// ----- design/ks_div.sv -----
// Restoring divider, one quotient bit per cycle: q = (rem0 << 16) / den.
// Needs rem0 < den. Depends on ks_pkg.
`default_nettype none
module ks_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [ks_pkg::TIME_W-1:0]   rem0,
  input  wire [ks_pkg::TIME_W-1:0]   den,
  output logic                       done,
  output logic [ks_pkg::FRAC_W-1:0]  quot
);
  import ks_pkg::*;

  localparam int CW = $clog2(FRAC_W);

  logic [TIME_W-1:0]          rem_r, den_r;
  logic [FRAC_W-1:0]          q_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;
  logic [TIME_W:0]            sh, diff;
  logic                       ge;

  assign sh   = {rem_r, 1'b0};
  assign diff = sh - {1'b0, den_r};
  assign ge   = (sh >= {1'b0, den_r});
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
      q_r   <= {q_r[FRAC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(FRAC_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(FRAC_W - 1)) busy_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/ks_back.sv -----
// Back end: key table, segment walk, fraction divide, per-component lerp
// and the output register. Depends on ks_pkg and ks_div.
`default_nettype none
module ks_back #(
  parameter int MAX_KEYS = ks_pkg::KS_MAX_KEYS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [ks_pkg::CNT_W-1:0]      key_count,
  input  wire                          q_valid,
  input  ks_pkg::item_t                q_item,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [ks_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ks_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);

  key_t       mem [MAX_KEYS];
  key_t       rdata_r;
  logic [IW-1:0] raddr;
  logic       mem_we;

  bk_state_t  state_r, state_nxt;
  logic [TIME_W-1:0] t_r, t0_r;
  logic signed [VAL_W-1:0] v0_r [NCOMP];
  logic signed [VAL_W-1:0] v1_r [NCOMP];
  logic signed [VAL_W-1:0] res_r [NCOMP];
  logic [IW-1:0] i_r, last_r, seg_r, last_nxt;
  logic [1:0]  comp_r;
  logic [FRAC_W-1:0] f_r;
  logic signed [VAL_W+FRAC_W:0] prod_r;
  logic signed [VAL_W:0] dif;
  logic signed [VAL_W+FRAC_W:0] prod_shr;

  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic       out_free;

  logic       found, at_last, seg0_hit;
  logic       div_start, div_done;
  logic [FRAC_W-1:0] div_q;

  assign out_free = !out_valid_r || out_tready;
  assign found    = (t_r < rdata_r.time_point);
  assign at_last  = (IW'(i_r + 1'b1) == last_r);
  assign seg0_hit = (last_r == '0) || (t_r <= rdata_r.time_point);

  // clamp of the register: zero means one key, above the table means all
  always_comb begin
    if (key_count == '0) begin
      last_nxt = '0;
    end else if (int'(key_count) > MAX_KEYS) begin
      last_nxt = IW'(MAX_KEYS - 1);
    end else begin
      last_nxt = IW'(key_count - 1'b1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid && q_item.is_query) state_nxt = BK_RD0;
      BK_RD0:  state_nxt = seg0_hit ? BK_DONE : BK_WALK;
      BK_WALK: begin
        if (found) state_nxt = BK_DIV;
        else if (at_last) state_nxt = BK_DONE;
      end
      BK_DIV:  if (div_done) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_ADD;
      BK_ADD:  state_nxt = (comp_r == 2'd2) ? BK_DONE : BK_MUL;
      BK_DONE: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    raddr     = '0;
    case (state_r)
      BK_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid && !q_item.is_query && (int'(q_item.slot) < MAX_KEYS);
      end
      BK_RD0:  raddr = IW'(1);
      BK_WALK: begin
        raddr     = IW'({1'b0, i_r} + 2'd2);
        div_start = found;
      end
      default: ;
    endcase
  end

  ks_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .rem0  (t_r - t0_r),
    .den   (rdata_r.time_point - t0_r),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IW'(q_item.slot)] <= key_t'{q_item.time_point, q_item.vz, q_item.vy, q_item.vx};
    end
    rdata_r <= mem[raddr];
  end

  assign dif      = {v1_r[comp_r][VAL_W-1], v1_r[comp_r]} - {v0_r[comp_r][VAL_W-1], v0_r[comp_r]};
  assign prod_shr = prod_r >>> FRAC_W;

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        t_r    <= q_item.time_point;
        last_r <= last_nxt;
      end
      BK_RD0: begin
        t0_r     <= rdata_r.time_point;
        v0_r[0]  <= rdata_r.vx;
        v0_r[1]  <= rdata_r.vy;
        v0_r[2]  <= rdata_r.vz;
        res_r[0] <= rdata_r.vx;
        res_r[1] <= rdata_r.vy;
        res_r[2] <= rdata_r.vz;
        seg_r    <= '0;
        i_r      <= '0;
      end
      BK_WALK: begin
        if (found) begin
          v1_r[0] <= rdata_r.vx;
          v1_r[1] <= rdata_r.vy;
          v1_r[2] <= rdata_r.vz;
          seg_r   <= i_r;
          comp_r  <= 2'd0;
        end else begin
          t0_r     <= rdata_r.time_point;
          v0_r[0]  <= rdata_r.vx;
          v0_r[1]  <= rdata_r.vy;
          v0_r[2]  <= rdata_r.vz;
          res_r[0] <= rdata_r.vx;
          res_r[1] <= rdata_r.vy;
          res_r[2] <= rdata_r.vz;
          seg_r    <= last_r;
          i_r      <= IW'(i_r + 1'b1);
        end
      end
      BK_DIV: if (div_done) f_r <= div_q;
      BK_MUL: prod_r <= dif * $signed({1'b0, f_r});
      BK_ADD: begin
        res_r[comp_r] <= v0_r[comp_r] + prod_shr[VAL_W-1:0];
        comp_r        <= comp_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == BK_DONE) && out_free) begin
      out_data_r <= OUT_TDATA_W'({SEG_W'(seg_r), res_r[2], res_r[1], res_r[0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == BK_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- design/ks_checker.sv -----
// Port-level checks for the keyframe linear sampler, bound to the top level.
// Depends on ks_pkg.
`default_nettype none
module ks_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            in_tuser,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [ks_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ks_pkg::*;

  logic [2:0] pend_r;
  logic       q_in, r_out;

  assign q_in  = in_tvalid && in_tready && (in_tuser == KIND_QUERY);
  assign r_out = out_tvalid && out_tready;

  // queries taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_r + {2'b0, q_in} - {2'b0, r_out};
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    r_out |-> pend_r != 3'd0)
    else $error("result without a pending query");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more queries in flight than storage");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keyframe_linear_sampler ks_checker u_ks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
